// File: hdl/clp3d_pkg.sv
// Shared widths, types and constants for the closest-points block.
package clp3d_pkg;

    localparam int CW      = 32;             // coordinate width
    localparam int DW      = CW + 1;         // difference vector width
    localparam int PW      = 2 * DW;         // one dot term
    localparam int DOT_W   = PW + 2;         // sum of three terms
    localparam int MAG1_W  = DOT_W - 1;      // dot product magnitude
    localparam int S1W     = 2 * MAG1_W + 1; // signed product of two dots
    localparam int NUM_W   = S1W + 1;        // den / numerator, signed
    localparam int NMAG_W  = NUM_W - 1;      // den / numerator magnitude
    localparam int QB      = CW + 1;         // quotient bits before overflow
    localparam int PRODW   = NMAG_W + DW;    // numerator times diff
    localparam int REM_W   = PRODW + 1;      // divider remainder
    localparam int SUMW    = CW + 3;         // start plus offset

    localparam int LIMB    = 32;
    localparam int MUL_AN  = (NMAG_W + LIMB - 1) / LIMB;
    localparam int MUL_BN  = 3;
    localparam int MUL_A_W = MUL_AN * LIMB;
    localparam int MUL_B_W = MUL_BN * LIMB;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // end-to-end latency: front end, two multipliers, divider, output reg
    localparam int LATENCY = 19 + QB;

    // dot product slots
    localparam int D1343 = 0;
    localparam int D4321 = 1;
    localparam int D1321 = 2;
    localparam int D4343 = 3;
    localparam int D2121 = 4;
    localparam int NDOT  = 5;

    localparam logic [CW-1:0] OUT_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] OUT_LO = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SUMW-1:0] SUM_HI = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SUM_LO = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [2:0][CW-1:0] a_start;
        logic [2:0][CW-1:0] b_start;
        logic [2:0][DW-1:0] d21;
        logic [2:0][DW-1:0] d43;
    } geo_t;

    typedef struct packed {
        logic [NMAG_W-1:0] den_mag;
        logic [NMAG_W-1:0] na_mag;
        logic [NMAG_W-1:0] nb_mag;
        logic              den_neg;
        logic              na_neg;
        logic              nb_neg;
        logic              den_zero;
        logic [2:0][DW-1:0] p21_mag;
        logic [2:0][DW-1:0] p43_mag;
        logic [2:0]        p21_neg;
        logic [2:0]        p43_neg;
    } ctl_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [NMAG_W-1:0]    den;
        logic [QB-1:0]        q;
        logic                 ovf;
        logic                 neg;
        logic signed [CW-1:0] start;
    } div_t;

endpackage

// File: hdl/closest_points_two_lines_3d_top.sv
// Top level: shortest segment between two 3D lines, fully pipelined.
//
// Usage:
//   A word is two lines, each a start and end point in signed Q16.16.
//   It is taken at a rising edge with start high and busy low. busy stays
//   low: a new word may be issued every cycle.
//   Each word yields one result word: strobe is high for one cycle with the
//   closest point on each line and no_solution. The receiver cannot stall.
// Pipeline from the accepting edge to the strobe cycle: front end,
//   den/numerator multiply and combine, offset multiply, divider, output
//   register. Throughput: one word per cycle; the 33-stage restoring
//   divider, one quotient bit per stage, sets the depth.
// Reset: rst_n low clears all valid bits; words in flight are dropped.
// A zero-length line or parallel lines give a zero denominator; the word
//   then comes out with no_solution high and all coordinates zero.
// Offsets mu*p are rounded to nearest, ties away from zero, and the sums
//   saturate to the 32-bit signed range.
module closest_points_two_lines_3d_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [clp3d_pkg::CW-1:0]   line_a_start_x,
    input  logic signed [clp3d_pkg::CW-1:0]   line_a_start_y,
    input  logic signed [clp3d_pkg::CW-1:0]   line_a_start_z,
    input  logic signed [clp3d_pkg::CW-1:0]   line_a_end_x,
    input  logic signed [clp3d_pkg::CW-1:0]   line_a_end_y,
    input  logic signed [clp3d_pkg::CW-1:0]   line_a_end_z,
    input  logic signed [clp3d_pkg::CW-1:0]   line_b_start_x,
    input  logic signed [clp3d_pkg::CW-1:0]   line_b_start_y,
    input  logic signed [clp3d_pkg::CW-1:0]   line_b_start_z,
    input  logic signed [clp3d_pkg::CW-1:0]   line_b_end_x,
    input  logic signed [clp3d_pkg::CW-1:0]   line_b_end_y,
    input  logic signed [clp3d_pkg::CW-1:0]   line_b_end_z,
    output logic                              strobe,
    output logic signed [clp3d_pkg::CW-1:0]   near_a_x,
    output logic signed [clp3d_pkg::CW-1:0]   near_a_y,
    output logic signed [clp3d_pkg::CW-1:0]   near_a_z,
    output logic signed [clp3d_pkg::CW-1:0]   near_b_x,
    output logic signed [clp3d_pkg::CW-1:0]   near_b_y,
    output logic signed [clp3d_pkg::CW-1:0]   near_b_z,
    output logic                              no_solution
);
    import clp3d_pkg::*;

    // pipeline stage numbers, counted from the accepting edge
    localparam int S_NUM  = 11;   // den and numerators ready
    localparam int S_DIV  = 15;   // divider inputs ready
    localparam int S_LAST = LATENCY - 1;

    logic signed [CW-1:0] as_w [3];
    logic signed [CW-1:0] ae_w [3];
    logic signed [CW-1:0] bs_w [3];
    logic signed [CW-1:0] be_w [3];

    assign as_w = '{line_a_start_x, line_a_start_y, line_a_start_z};
    assign ae_w = '{line_a_end_x, line_a_end_y, line_a_end_z};
    assign bs_w = '{line_b_start_x, line_b_start_y, line_b_start_z};
    assign be_w = '{line_b_end_x, line_b_end_y, line_b_end_z};

    // valid bit per stage
    logic [S_LAST:1] v_reg;

    // geometry rides along until the divider
    geo_t                  geo_pipe_reg [1:S_DIV];
    logic signed [DW-1:0]  d13_reg [3];
    logic signed [PW-1:0]  term_reg [3*NDOT];
    logic signed [DOT_W-1:0] dot_reg [NDOT];
    logic [MAG1_W-1:0]     dmag_reg [NDOT];
    logic [NDOT-1:0]       dsgn_reg;
    logic [5:0]            psgn_reg [4];
    logic [5:0]            psgn_next;
    logic signed [S1W-1:0] sprod_reg [6];
    logic signed [NUM_W-1:0] num_reg [3];   // den, na, nb
    ctl_t                  ctl_pipe_reg [S_NUM:S_DIV];
    ctl_t                  ctl_next;
    logic [S_LAST:S_DIV+1] zero_pipe_reg;

    logic [MUL_A_W-1:0] m1_a [6];
    logic [MUL_B_W-1:0] m1_b [6];
    logic [MUL_P_W-1:0] m1_p [6];
    logic [MUL_A_W-1:0] m2_a [6];
    logic [MUL_B_W-1:0] m2_b [6];
    logic [MUL_P_W-1:0] m2_p [6];
    logic [CW-1:0]      div_res [6];

    logic               strobe_reg;
    logic               no_solution_reg;
    logic [CW-1:0]      near_reg [6];

    assign busy = 1'b0;

    // valid and flag shift lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg           <= '0;
            strobe_reg      <= 1'b0;
            no_solution_reg <= 1'b0;
        end
        else
        begin
            v_reg           <= {v_reg[S_LAST-1:1], start};
            strobe_reg      <= v_reg[S_LAST];
            no_solution_reg <= v_reg[S_LAST] && zero_pipe_reg[S_LAST];
        end
    end

    // front end: differences, dot terms, dot sums, magnitudes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d13_reg[i]                <= DW'(as_w[i]) - DW'(bs_w[i]);
            geo_pipe_reg[1].a_start[i] <= as_w[i];
            geo_pipe_reg[1].b_start[i] <= bs_w[i];
            geo_pipe_reg[1].d21[i]     <= DW'(ae_w[i]) - DW'(as_w[i]);
            geo_pipe_reg[1].d43[i]     <= DW'(be_w[i]) - DW'(bs_w[i]);
        end
        for (int k = 2; k <= S_DIV; k++)
            geo_pipe_reg[k] <= geo_pipe_reg[k-1];

        for (int i = 0; i < 3; i++)
        begin
            term_reg[3*D1343+i] <= PW'(d13_reg[i]) * PW'($signed(geo_pipe_reg[1].d43[i]));
            term_reg[3*D4321+i] <= PW'($signed(geo_pipe_reg[1].d43[i]))
                                 * PW'($signed(geo_pipe_reg[1].d21[i]));
            term_reg[3*D1321+i] <= PW'(d13_reg[i]) * PW'($signed(geo_pipe_reg[1].d21[i]));
            term_reg[3*D4343+i] <= PW'($signed(geo_pipe_reg[1].d43[i]))
                                 * PW'($signed(geo_pipe_reg[1].d43[i]));
            term_reg[3*D2121+i] <= PW'($signed(geo_pipe_reg[1].d21[i]))
                                 * PW'($signed(geo_pipe_reg[1].d21[i]));
        end

        for (int d = 0; d < NDOT; d++)
        begin
            dot_reg[d]  <= DOT_W'(term_reg[3*d]) + DOT_W'(term_reg[3*d+1])
                         + DOT_W'(term_reg[3*d+2]);
            dmag_reg[d] <= MAG1_W'(dot_reg[d][DOT_W-1] ? -dot_reg[d] : dot_reg[d]);
            dsgn_reg[d] <= dot_reg[d][DOT_W-1];
        end
    end

    // den = d2121*d4343 - d4321^2, na = d1343*d4321 - d1321*d4343,
    // nb = d1343*d2121 - d1321*d4321
    always_comb
    begin
        m1_a[0] = MUL_A_W'(dmag_reg[D2121]);  m1_b[0] = MUL_B_W'(dmag_reg[D4343]);
        m1_a[1] = MUL_A_W'(dmag_reg[D4321]);  m1_b[1] = MUL_B_W'(dmag_reg[D4321]);
        m1_a[2] = MUL_A_W'(dmag_reg[D1343]);  m1_b[2] = MUL_B_W'(dmag_reg[D4321]);
        m1_a[3] = MUL_A_W'(dmag_reg[D1321]);  m1_b[3] = MUL_B_W'(dmag_reg[D4343]);
        m1_a[4] = MUL_A_W'(dmag_reg[D1343]);  m1_b[4] = MUL_B_W'(dmag_reg[D2121]);
        m1_a[5] = MUL_A_W'(dmag_reg[D1321]);  m1_b[5] = MUL_B_W'(dmag_reg[D4321]);
        psgn_next = {dsgn_reg[D1321] ^ dsgn_reg[D4321],
                     dsgn_reg[D1343],
                     dsgn_reg[D1321],
                     dsgn_reg[D1343] ^ dsgn_reg[D4321],
                     1'b0,
                     1'b0};
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_mul1
        clp3d_mul u_mul (
            .clk (clk),
            .a   (m1_a[g]),
            .b   (m1_b[g]),
            .p   (m1_p[g])
        );
    end

    // signed products, combine, then magnitudes for the second multiply
    always_comb
    begin
        ctl_next.den_neg  = num_reg[0][NUM_W-1];
        ctl_next.na_neg   = num_reg[1][NUM_W-1];
        ctl_next.nb_neg   = num_reg[2][NUM_W-1];
        ctl_next.den_mag  = NMAG_W'(ctl_next.den_neg ? -num_reg[0] : num_reg[0]);
        ctl_next.na_mag   = NMAG_W'(ctl_next.na_neg ? -num_reg[1] : num_reg[1]);
        ctl_next.nb_mag   = NMAG_W'(ctl_next.nb_neg ? -num_reg[2] : num_reg[2]);
        ctl_next.den_zero = num_reg[0] == '0;
        for (int i = 0; i < 3; i++)
        begin
            ctl_next.p21_neg[i] = geo_pipe_reg[S_NUM-1].d21[i][DW-1];
            ctl_next.p43_neg[i] = geo_pipe_reg[S_NUM-1].d43[i][DW-1];
            ctl_next.p21_mag[i] = ctl_next.p21_neg[i] ? -geo_pipe_reg[S_NUM-1].d21[i]
                                                      : geo_pipe_reg[S_NUM-1].d21[i];
            ctl_next.p43_mag[i] = ctl_next.p43_neg[i] ? -geo_pipe_reg[S_NUM-1].d43[i]
                                                      : geo_pipe_reg[S_NUM-1].d43[i];
        end
    end

    always_ff @(posedge clk)
    begin
        psgn_reg[0] <= psgn_next;
        for (int k = 1; k < 4; k++)
            psgn_reg[k] <= psgn_reg[k-1];
        for (int k = 0; k < 6; k++)
            sprod_reg[k] <= psgn_reg[3][k] ? -S1W'(m1_p[k][S1W-2:0])
                                           : S1W'(m1_p[k][S1W-2:0]);
        num_reg[0] <= NUM_W'(sprod_reg[0]) - NUM_W'(sprod_reg[1]);
        num_reg[1] <= NUM_W'(sprod_reg[2]) - NUM_W'(sprod_reg[3]);
        num_reg[2] <= NUM_W'(sprod_reg[4]) - NUM_W'(sprod_reg[5]);
        ctl_pipe_reg[S_NUM] <= ctl_next;
        for (int k = S_NUM + 1; k <= S_DIV; k++)
            ctl_pipe_reg[k] <= ctl_pipe_reg[k-1];
        zero_pipe_reg <= {zero_pipe_reg[S_LAST-1:S_DIV+1], ctl_pipe_reg[S_DIV].den_zero};
    end

    // numerator times each difference component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m2_a[i]   = MUL_A_W'(ctl_pipe_reg[S_NUM].na_mag);
            m2_b[i]   = MUL_B_W'(ctl_pipe_reg[S_NUM].p21_mag[i]);
            m2_a[3+i] = MUL_A_W'(ctl_pipe_reg[S_NUM].nb_mag);
            m2_b[3+i] = MUL_B_W'(ctl_pipe_reg[S_NUM].p43_mag[i]);
        end
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_mul2
        clp3d_mul u_mul (
            .clk (clk),
            .a   (m2_a[g]),
            .b   (m2_b[g]),
            .p   (m2_p[g])
        );
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        clp3d_div u_div_a (
            .clk      (clk),
            .prod     (m2_p[g][PRODW-1:0]),
            .den      (ctl_pipe_reg[S_DIV].den_mag),
            .neg      (ctl_pipe_reg[S_DIV].na_neg ^ ctl_pipe_reg[S_DIV].p21_neg[g]
                       ^ ctl_pipe_reg[S_DIV].den_neg),
            .start_pt ($signed(geo_pipe_reg[S_DIV].a_start[g])),
            .result   (div_res[g])
        );
        clp3d_div u_div_b (
            .clk      (clk),
            .prod     (m2_p[3+g][PRODW-1:0]),
            .den      (ctl_pipe_reg[S_DIV].den_mag),
            .neg      (ctl_pipe_reg[S_DIV].nb_neg ^ ctl_pipe_reg[S_DIV].p43_neg[g]
                       ^ ctl_pipe_reg[S_DIV].den_neg),
            .start_pt ($signed(geo_pipe_reg[S_DIV].b_start[g])),
            .result   (div_res[3+g])
        );
    end

    // output register; coordinates forced to zero with no solution
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
            near_reg[k] <= zero_pipe_reg[S_LAST] ? '0 : div_res[k];
    end

    assign strobe      = strobe_reg;
    assign no_solution = no_solution_reg;
    assign near_a_x    = near_reg[0];
    assign near_a_y    = near_reg[1];
    assign near_a_z    = near_reg[2];
    assign near_b_x    = near_reg[3];
    assign near_b_y    = near_reg[4];
    assign near_b_z    = near_reg[5];

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY strobe)
        else $error("accepted word did not produce a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start, LATENCY))
        else $error("result without an accepted word");

    a_flag_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        no_solution |-> strobe)
        else $error("no_solution outside a result");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        no_solution |-> (near_a_x == '0 && near_a_y == '0 && near_a_z == '0
                         && near_b_x == '0 && near_b_y == '0 && near_b_z == '0))
        else $error("nonzero points with no_solution");

endmodule

// File: hdl/clp3d_mul.sv
// Pipelined unsigned multiplier built from 32x32 partial products; registers partials, rows, partial sums, product.
module clp3d_mul (
    input  logic                           clk,
    input  logic [clp3d_pkg::MUL_A_W-1:0] a,
    input  logic [clp3d_pkg::MUL_B_W-1:0] b,
    output logic [clp3d_pkg::MUL_P_W-1:0] p
);
    import clp3d_pkg::*;

    logic [2*LIMB-1:0]        pp_reg [MUL_BN][MUL_AN];
    logic [MUL_A_W+LIMB-1:0]  row_reg [MUL_BN];
    logic [MUL_A_W+LIMB-1:0]  row_next [MUL_BN];
    logic [MUL_A_W+2*LIMB-1:0] s01_reg;
    logic [MUL_A_W+LIMB-1:0]  s2_reg;
    logic [MUL_P_W-1:0]       p_reg;

    // even partials of one row do not overlap, nor do odd ones: one add per row
    always_comb
    begin
        logic [MUL_A_W+LIMB-1:0] even;
        logic [MUL_A_W+LIMB-1:0] odd;
        for (int j = 0; j < MUL_BN; j++)
        begin
            even = '0;
            odd  = '0;
            for (int i = 0; i < MUL_AN; i++)
            begin
                if (i % 2 == 0)
                    even[i*LIMB +: 2*LIMB] = pp_reg[j][i];
                else
                    odd[i*LIMB +: 2*LIMB] = pp_reg[j][i];
            end
            row_next[j] = even + odd;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MUL_BN; j++)
        begin
            for (int i = 0; i < MUL_AN; i++)
                pp_reg[j][i] <= a[i*LIMB +: LIMB] * b[j*LIMB +: LIMB];
            row_reg[j] <= row_next[j];
        end
        s01_reg <= {{LIMB{1'b0}}, row_reg[0]} + {row_reg[1], {LIMB{1'b0}}};
        s2_reg  <= row_reg[2];
        p_reg   <= {{LIMB{1'b0}}, s01_reg} + {s2_reg, {2*LIMB{1'b0}}};
    end

    assign p = p_reg;

endmodule

// File: hdl/clp3d_div.sv
// One lane: restoring divide one quotient bit per stage, round, add, saturate.
module clp3d_div (
    input  logic                                clk,
    input  logic [clp3d_pkg::PRODW-1:0]         prod,
    input  logic [clp3d_pkg::NMAG_W-1:0]        den,
    input  logic                                neg,
    input  logic signed [clp3d_pkg::CW-1:0]     start_pt,
    output logic [clp3d_pkg::CW-1:0]            result
);
    import clp3d_pkg::*;

    div_t st_reg [QB+1];
    logic [QB:0]           qv_reg;
    logic                  r_ovf_reg;
    logic                  r_neg_reg;
    logic signed [CW-1:0]  r_start_reg;
    logic [CW-1:0]         result_reg;
    logic [CW-1:0]         result_next;

    // entry: quotient of 2^QB or more always saturates
    always_ff @(posedge clk)
    begin
        st_reg[0].rem   <= REM_W'(prod);
        st_reg[0].den   <= den;
        st_reg[0].q     <= '0;
        st_reg[0].ovf   <= REM_W'(prod) >= (REM_W'(den) << QB);
        st_reg[0].neg   <= neg;
        st_reg[0].start <= start_pt;
    end

    for (genvar g = 0; g < QB; g++)
    begin : g_step
        logic [REM_W:0] diff;
        div_t           st_next;
        assign diff = {1'b0, st_reg[g].rem} - {1'b0, REM_W'(st_reg[g].den) << (QB - 1 - g)};
        always_comb
        begin
            st_next = st_reg[g];
            if (!diff[REM_W])
            begin
                st_next.rem         = diff[REM_W-1:0];
                st_next.q[QB-1-g]   = 1'b1;
            end
        end
        always_ff @(posedge clk)
            st_reg[g+1] <= st_next;
    end

    // round half away from zero on the magnitude
    always_ff @(posedge clk)
    begin
        qv_reg <= {1'b0, st_reg[QB].q}
                + (QB+1)'({st_reg[QB].rem, 1'b0} >= (REM_W+1)'(st_reg[QB].den));
        r_ovf_reg   <= st_reg[QB].ovf;
        r_neg_reg   <= st_reg[QB].neg;
        r_start_reg <= st_reg[QB].start;
    end

    always_comb
    begin
        logic [SUMW-1:0]        magx;
        logic signed [SUMW-1:0] sum_w;
        magx  = SUMW'(qv_reg[QB-1:0]);
        sum_w = SUMW'(r_start_reg) + (r_neg_reg ? -magx : magx);
        if (r_ovf_reg || qv_reg[QB])
            result_next = r_neg_reg ? OUT_LO : OUT_HI;
        else if (sum_w > SUM_HI)
            result_next = OUT_HI;
        else if (sum_w < SUM_LO)
            result_next = OUT_LO;
        else
            result_next = CW'(sum_w);
    end

    always_ff @(posedge clk)
        result_reg <= result_next;

    assign result = result_reg;

endmodule
